/* rtl/command_line_tokenizer_core_defines.svh */
// Assertion macros used by the tokenizer top level.
`ifndef COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/clt_pkg.sv */
// Shared types and constants of the command line tokenizer.
package clt_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END_ARG  = 2'd1,
    KIND_END_LINE = 2'd2
  } kind_e;

  // Most results one byte can cause
  localparam int unsigned SLOTS = 3;

  // One result request
  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_val;
    logic [7:0] index;
    logic [7:0] total;
  } rec_t;

  // All results of one byte, in order of slot 0 to slot 2
  typedef struct packed {
    logic [SLOTS-1:0] valid;
    rec_t [SLOTS-1:0] slot;
  } bundle_t;

endpackage

/* rtl/clt_front.sv */
// Front end: parse state, byte classification and result bundle building.
module clt_front #(
  parameter int unsigned COUNT_MAX = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      byte_value_i,
  input  logic            cfg_we_i,
  input  logic [7:0]      arg_limit_i,
  output logic            bndl_push_o,
  output clt_pkg::bundle_t bndl_o
);

  localparam int unsigned CntW = $clog2(COUNT_MAX + 1);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;
  localparam logic [CntW-1:0] CntMax = CntW'(COUNT_MAX);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2
  } mode_e;

  mode_e           mode_q, mode_d, eff_mode;
  logic            qs_q, qs_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      limit_q;

  logic            active, in_arg, is_space, is_quote, is_escapable;
  logic            stop, skip, finish;
  logic [7:0]      qchar;
  logic [CntW-1:0] cnt_inc, cnt_fin;
  logic [CmpW-1:0] cnt_ext, cnt_fin_ext, limit_ext;
  logic [7:0]      cnt_now8, cnt_fin8;
  clt_pkg::bundle_t bndl;

  // Classify the byte
  assign is_space     = (byte_value_i == ChSpace) || (byte_value_i == ChTab) ||
                        (byte_value_i == ChNl);
  assign is_quote     = (byte_value_i == ChDquote) || (byte_value_i == ChSquote);
  assign is_escapable = is_quote || (byte_value_i == ChBslash);
  assign in_arg       = (mode_q != MODE_BETWEEN);
  assign qchar        = qs_q ? ChSquote : ChDquote;

  // Check the argument limit and form the count after an argument ends
  assign cnt_ext     = CmpW'(cnt_q);
  assign limit_ext   = CmpW'(limit_q);
  assign active      = (limit_q == 8'd0) || (cnt_ext < limit_ext);
  assign cnt_inc     = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;
  assign cnt_fin     = active ? cnt_inc : cnt_q;
  assign cnt_fin_ext = CmpW'(cnt_fin);
  assign cnt_now8    = cnt_ext[7:0];
  assign cnt_fin8    = cnt_fin_ext[7:0];

  // Build the result bundle and the next parse state
  always_comb begin
    mode_d   = mode_q;
    qs_d     = qs_q;
    esc_d    = esc_q;
    cnt_d    = cnt_q;
    eff_mode = mode_q;
    stop     = 1'b0;
    skip     = 1'b0;
    finish   = 1'b0;

    bndl.valid = '0;
    bndl.slot[0] = '{kind: clt_pkg::KIND_CHAR, byte_val: ChBslash,
                     index: cnt_now8, total: cnt_now8};
    bndl.slot[1] = '{kind: clt_pkg::KIND_CHAR, byte_val: byte_value_i,
                     index: cnt_now8, total: cnt_now8};
    bndl.slot[2] = '{kind: clt_pkg::KIND_END_LINE, byte_val: 8'd0,
                     index: cnt_now8, total: cnt_now8};

    // Resolve a pending backslash
    if (in_arg && esc_q) begin
      esc_d         = 1'b0;
      bndl.valid[0] = active;
      if (is_escapable) begin
        bndl.slot[0].byte_val = byte_value_i;
        stop                  = 1'b1;
      end
    end

    if (!stop) begin
      if (byte_value_i == ChNul) begin
        // End of line: close any open argument, report the count, reset
        if (in_arg) begin
          bndl.valid[1]          = active;
          bndl.slot[1].kind      = clt_pkg::KIND_END_ARG;
          bndl.slot[1].byte_val  = 8'd0;
          bndl.slot[1].total     = cnt_fin8;
          bndl.slot[2].index     = cnt_fin8;
          bndl.slot[2].total     = cnt_fin8;
        end
        bndl.valid[2] = 1'b1;
        mode_d        = MODE_BETWEEN;
        qs_d          = 1'b0;
        esc_d         = 1'b0;
        cnt_d         = '0;
      end else begin
        // Open an argument or skip whitespace
        if (mode_q == MODE_BETWEEN) begin
          if (is_space) begin
            skip = 1'b1;
          end else if (is_quote) begin
            mode_d = MODE_QUOTED;
            qs_d   = (byte_value_i == ChSquote);
            skip   = 1'b1;
          end else begin
            mode_d   = MODE_PLAIN;
            eff_mode = MODE_PLAIN;
          end
        end

        if (!skip) begin
          if (eff_mode == MODE_QUOTED) begin
            finish = (byte_value_i == ChNl) || (byte_value_i == qchar);
          end else begin
            finish = is_space;
          end

          if (finish) begin
            bndl.valid[1]         = active;
            bndl.slot[1].kind     = clt_pkg::KIND_END_ARG;
            bndl.slot[1].byte_val = 8'd0;
            bndl.slot[1].total    = cnt_fin8;
            cnt_d                 = cnt_fin;
            mode_d                = MODE_BETWEEN;
            esc_d                 = 1'b0;
          end else if (byte_value_i == ChBslash) begin
            esc_d = 1'b1;
          end else begin
            bndl.valid[1] = active;
          end
        end
      end
    end
  end

  // Hold parse state and the limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BETWEEN;
      qs_q    <= 1'b0;
      esc_q   <= 1'b0;
      cnt_q   <= '0;
      limit_q <= 8'd0;
    end else begin
      if (take_i) begin
        mode_q <= mode_d;
        qs_q   <= qs_d;
        esc_q  <= esc_d;
        cnt_q  <= cnt_d;
      end
      if (cfg_we_i) begin
        limit_q <= arg_limit_i;
      end
    end
  end

  // Push only bytes that cause results
  assign bndl_push_o = take_i && (|bndl.valid);
  assign bndl_o      = bndl;

endmodule

/* rtl/clt_fifo.sv */
// Bundle queue between the front end and the back end.
module clt_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clt_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output clt_pkg::bundle_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  clt_pkg::bundle_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Store pushed bundles
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/clt_back.sv */
// Back end: walk the slots of each bundle and feed the output register.
module clt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_empty_i,
  input  clt_pkg::bundle_t head_i,
  output logic             head_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output clt_pkg::rec_t    rec_o,
  output logic             last_o
);

  localparam int unsigned Slots = clt_pkg::SLOTS;

  logic [Slots-1:0] done_q, done_d;
  logic [Slots-1:0] remain, sel, remain_after;
  logic             out_valid_q, out_take, load, sel_last;
  clt_pkg::rec_t    rec_q, sel_rec;
  logic             last_q;

  // Pick the oldest slot still to send
  assign remain = head_i.valid & ~done_q;

  always_comb begin
    sel     = '0;
    sel_rec = head_i.slot[0];
    priority if (remain[0]) begin
      sel[0]  = 1'b1;
      sel_rec = head_i.slot[0];
    end else if (remain[1]) begin
      sel[1]  = 1'b1;
      sel_rec = head_i.slot[1];
    end else if (remain[2]) begin
      sel[2]  = 1'b1;
      sel_rec = head_i.slot[2];
    end else begin
      sel = '0;
    end
  end

  assign remain_after = remain & ~sel;
  assign sel_last     = (remain_after == '0);
  assign out_take     = pop_i && out_valid_q;
  assign load         = !head_empty_i && (!out_valid_q || out_take);
  assign head_pop_o   = load && sel_last;

  // Mark sent slots, clear when the bundle leaves
  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = sel_last ? '0 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the shown result
  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q  <= sel_rec;
      last_q <= sel_last;
    end
  end

  assign empty_o = !out_valid_q;
  assign rec_o   = rec_q;
  assign last_o  = last_q;

endmodule

/* rtl/command_line_tokenizer_core.sv */
// Command line tokenizer top level: front end, bundle queue, back end.
//
//   channel  | handshake    | payload
//   ---------+--------------+-----------------------------------------------
//   input    | push / full  | byte_value_i
//   result   | pop / empty  | result_kind_o out_byte_o arg_index_o
//            |              | arg_total_o last_of_run_o
//   config   | cfg_we_i     | arg_limit_i
//
// The front end takes one byte per cycle while the bundle queue has room.
// Each byte causes zero to three results; the back end sends one result per
// cycle while pop is held, one slot of the head bundle after another.
// The first result of a byte passes the bundle queue and then the output register.
// Reset clears the parse state, the argument count, the limit, the bundle queue
// and the output register. A stalled result side fills the bundle queue
// (FIFO_DEPTH bundles) and then raises full.
module command_line_tokenizer_core #(
  parameter int unsigned COUNT_MAX  = 255,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_value_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] result_kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] arg_index_o,
  output logic [7:0] arg_total_o,
  output logic       last_of_run_o,
  input  logic       cfg_we_i,
  input  logic [7:0] arg_limit_i
);

  `include "command_line_tokenizer_core_defines.svh"

  logic             take, bndl_push, head_empty, head_pop;
  clt_pkg::bundle_t bndl, head;
  clt_pkg::rec_t    rec;
  logic             last;
  logic             shown_eol, shown_mark, took_mid;

  // Accept a byte request while the queue has room
  assign take = push && !full;

  clt_front #(
    .COUNT_MAX (COUNT_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .byte_value_i (byte_value_i),
    .cfg_we_i     (cfg_we_i),
    .arg_limit_i  (arg_limit_i),
    .bndl_push_o  (bndl_push),
    .bndl_o       (bndl)
  );

  clt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bndl_push),
    .data_i  (bndl),
    .full_o  (full),
    .pop_i   (head_pop),
    .empty_o (head_empty),
    .data_o  (head)
  );

  clt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_empty_i (head_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .rec_o        (rec),
    .last_o       (last)
  );

  // Drive result ports
  assign result_kind_o = rec.kind;
  assign out_byte_o    = rec.byte_val;
  assign arg_index_o   = rec.index;
  assign arg_total_o   = rec.total;
  assign last_of_run_o = last;

  // Conditions watched by the checks below
  assign shown_eol  = !empty && (result_kind_o == clt_pkg::KIND_END_LINE);
  assign shown_mark = !empty && (result_kind_o != clt_pkg::KIND_CHAR);
  assign took_mid   = pop && !empty && !last_of_run_o;

  // End of line is always the final result of its byte
  `CLT_ASSERT_IMP(a_eol_last, clk_i, rst_ni, shown_eol, last_of_run_o, "end of line not last")

  // End of line reports the same count in index and total
  `CLT_ASSERT_IMP(a_eol_count, clk_i, rst_ni, shown_eol, arg_index_o == arg_total_o, "eol count")

  // Only argument characters carry a byte
  `CLT_ASSERT_IMP(a_mark_byte, clk_i, rst_ni, shown_mark, out_byte_o == 8'd0, "mark has a byte")

  // A taken result that was not last is followed by another one
  `CLT_ASSERT_NEXT(a_run_cont, clk_i, rst_ni, took_mid, !empty, "run of results broken")

endmodule
